FILE: src/fcpq_pkg.sv
// ----------------------------------------------------------------------------
// fcpq_pkg
// Shared types and codes for the client play queue.
// ----------------------------------------------------------------------------
package fcpq_pkg;

    localparam int CLIENT_SLOTS = 4;
    localparam int SLOT_W       = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int CNT_W        = $clog2(CLIENT_SLOTS + 1);
    localparam int MAX_RESULTS  = 5;
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [15:0]       conn_t;
    typedef logic [2:0]        mode_t;
    typedef logic [2:0]        kind_t;
    typedef logic [2:0]        track_t;
    typedef logic [1:0]        ahead_t;

    localparam mode_t MODE_CONNECT    = 3'd0;
    localparam mode_t MODE_DISCONNECT = 3'd1;
    localparam mode_t MODE_WRITE      = 3'd2;
    localparam mode_t MODE_READ       = 3'd3;
    localparam mode_t MODE_SUBSCRIBE  = 3'd4;
    localparam mode_t MODE_FINISHED   = 3'd5;
    localparam mode_t MODE_BUSY       = 3'd6;

    localparam kind_t KIND_ACCEPT = 3'd0;
    localparam kind_t KIND_REFUSE = 3'd1;
    localparam kind_t KIND_REPLY  = 3'd2;
    localparam kind_t KIND_NOTE   = 3'd3;
    localparam kind_t KIND_PLAY   = 3'd4;
    localparam kind_t KIND_STOP   = 3'd5;

    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_6 = 8'h36;

    typedef struct packed {
        mode_t      mode;
        conn_t      conn_id;
        logic [7:0] cmd_byte;
        logic       notify_on;
    } req_t;

    typedef struct packed {
        kind_t  kind;
        conn_t  target_conn;
        logic   mine;
        ahead_t ahead;
        track_t track;
        logic   last;
    } res_t;

    typedef struct packed {
        logic   connect;
        logic   disconnect;
        logic   leave;
        logic   join_q;
        logic   set_track;
        logic   start;
        logic   stop;
        logic   set_sub;
        logic   sub_val;
        logic   set_busy;
        logic   clr_busy;
        slot_t  slot;
        slot_t  start_slot;
        track_t track;
        conn_t  conn;
        slot_t  join_rank;
    } tbl_cmd_t;

    typedef struct packed {
        logic   in_use;
        logic   waiting;
        slot_t  rank;
        track_t track;
        conn_t  conn;
    } slot_view_t;

    typedef struct packed {
        logic                    playing_valid;
        slot_t                   playing_slot;
        logic                    busy;
        logic [CLIENT_SLOTS-1:0] in_use;
        logic [CLIENT_SLOTS-1:0] subscribed;
    } tbl_stat_t;

endpackage

FILE: src/fcpq_req_if.sv
// ----------------------------------------------------------------------------
// fcpq_req_if
// Request channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
interface fcpq_req_if import fcpq_pkg::*; ();

    logic       valid;
    logic       ready;
    mode_t      mode;
    conn_t      conn_id;
    logic [7:0] cmd_byte;
    logic       notify_on;

    modport source (output valid, output mode, output conn_id, output cmd_byte,
                    output notify_on, input ready);
    modport sink   (input valid, input mode, input conn_id, input cmd_byte,
                    input notify_on, output ready);

endinterface

FILE: src/fcpq_res_if.sv
// ----------------------------------------------------------------------------
// fcpq_res_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface fcpq_res_if import fcpq_pkg::*; ();

    logic   valid;
    logic   ready;
    kind_t  kind;
    conn_t  target_conn;
    logic   mine;
    ahead_t ahead;
    track_t track;
    logic   last;

    modport source (output valid, output kind, output target_conn, output mine,
                    output ahead, output track, output last, input ready);
    modport sink   (input valid, input kind, input target_conn, input mine,
                    input ahead, input track, input last, output ready);

endinterface

FILE: src/fcpq_slot_table.sv
// ----------------------------------------------------------------------------
// fcpq_slot_table
// Client slot state and player state; applies one update command per cycle.
// ----------------------------------------------------------------------------
module fcpq_slot_table import fcpq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  tbl_cmd_t   cmd,
    input  slot_t      rd_idx,
    output slot_view_t view,
    output tbl_stat_t  stat
);

    logic [CLIENT_SLOTS-1:0] in_use_reg, in_use_next;
    logic [CLIENT_SLOTS-1:0] sub_reg, sub_next;
    logic [CLIENT_SLOTS-1:0] wait_reg, wait_next;
    slot_t                   rank_reg  [CLIENT_SLOTS];
    slot_t                   rank_next [CLIENT_SLOTS];
    track_t                  track_reg [CLIENT_SLOTS];
    track_t                  track_next[CLIENT_SLOTS];
    conn_t                   conn_reg  [CLIENT_SLOTS];
    logic                    pv_reg, pv_next;
    slot_t                   ps_reg, ps_next;
    logic                    busy_reg, busy_next;

    always_comb
    begin
        in_use_next = in_use_reg;
        sub_next    = sub_reg;
        wait_next   = wait_reg;
        rank_next   = rank_reg;
        track_next  = track_reg;
        pv_next     = pv_reg;
        ps_next     = ps_reg;
        busy_next   = busy_reg;

        if (cmd.connect)
        begin
            in_use_next[cmd.slot] = 1'b1;
            sub_next[cmd.slot]    = 1'b0;
            wait_next[cmd.slot]   = 1'b0;
            rank_next[cmd.slot]   = '0;
            track_next[cmd.slot]  = '0;
        end
        if (cmd.leave && wait_reg[cmd.slot])
        begin
            for (int t = 0; t < CLIENT_SLOTS; t++)
            begin
                if (slot_t'(t) != cmd.slot && wait_reg[t] && rank_reg[t] > rank_reg[cmd.slot])
                begin
                    rank_next[t] = rank_reg[t] - slot_t'(1);
                end
            end
            wait_next[cmd.slot] = 1'b0;
            rank_next[cmd.slot] = '0;
        end
        if (cmd.disconnect)
        begin
            in_use_next[cmd.slot] = 1'b0;
            sub_next[cmd.slot]    = 1'b0;
        end
        if (cmd.set_track)
        begin
            track_next[cmd.slot] = cmd.track;
        end
        if (cmd.join_q && !wait_reg[cmd.slot])
        begin
            wait_next[cmd.slot] = 1'b1;
            rank_next[cmd.slot] = cmd.join_rank;
        end
        if (cmd.set_sub)
        begin
            sub_next[cmd.slot] = cmd.sub_val;
        end
        if (cmd.stop)
        begin
            pv_next = 1'b0;
            ps_next = '0;
        end
        if (cmd.start)
        begin
            pv_next = 1'b1;
            ps_next = cmd.start_slot;
        end
        if (cmd.set_busy)
        begin
            busy_next = 1'b1;
        end
        if (cmd.clr_busy)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            sub_reg    <= '0;
            wait_reg   <= '0;
            for (int t = 0; t < CLIENT_SLOTS; t++)
            begin
                rank_reg[t]  <= '0;
                track_reg[t] <= '0;
            end
            pv_reg     <= 1'b0;
            ps_reg     <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            sub_reg    <= sub_next;
            wait_reg   <= wait_next;
            rank_reg   <= rank_next;
            track_reg  <= track_next;
            pv_reg     <= pv_next;
            ps_reg     <= ps_next;
            busy_reg   <= busy_next;
        end
    end

    // handle store: written on connect only
    always_ff @(posedge clk)
    begin
        if (cmd.connect)
        begin
            conn_reg[cmd.slot] <= cmd.conn;
        end
    end

    always_comb
    begin
        view.in_use     = in_use_reg[rd_idx];
        view.waiting    = wait_reg[rd_idx];
        view.rank       = rank_reg[rd_idx];
        view.track      = track_reg[rd_idx];
        view.conn       = conn_reg[rd_idx];

        stat.playing_valid = pv_reg;
        stat.playing_slot  = ps_reg;
        stat.busy          = busy_reg;
        stat.in_use        = in_use_reg;
        stat.subscribed    = sub_reg;
    end

endmodule

FILE: src/fcpq_seq.sv
// ----------------------------------------------------------------------------
// fcpq_seq
// Sequencer: slot scan, update decision, leading result, notification scan.
// ----------------------------------------------------------------------------
module fcpq_seq import fcpq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  req_t       req_data,
    output logic       req_ready,
    input  logic       res_free,
    output logic       emit,
    output res_t       res_data,
    output tbl_cmd_t   cmd,
    output slot_t      rd_idx,
    input  slot_view_t view,
    input  tbl_stat_t  stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_FIRST = 3'd3;
    localparam logic [2:0] ST_NOTE  = 3'd4;

    localparam int WIDE_W = SLOT_W + 2;
    typedef logic [WIDE_W-1:0] wide_t;

    logic [2:0]             state_reg, state_next;
    slot_t                  idx_reg, idx_next;
    req_t                   req_reg, req_next;
    logic                   found_v_reg, found_v_next;
    slot_t                  found_s_reg, found_s_next;
    logic                   free_v_reg, free_v_next;
    slot_t                  free_s_reg, free_s_next;
    logic                   head0_v_reg, head0_v_next;
    slot_t                  head0_s_reg, head0_s_next;
    logic                   head1_v_reg, head1_v_next;
    slot_t                  head1_s_reg, head1_s_next;
    cnt_t                   wait_cnt_reg, wait_cnt_next;
    kind_t                  first_kind_reg, first_kind_next;
    slot_t                  first_slot_reg, first_slot_next;
    logic                   has_first_reg, has_first_next;
    logic                   do_notes_reg, do_notes_next;
    logic [RES_CNT_W-1:0]   cnt_reg, cnt_next;

    logic [CLIENT_SLOTS-1:0] nmask;
    logic [CLIENT_SLOTS-1:0] above;
    logic                    played_found;
    logic                    start_ok;
    logic                    cap_hit;
    logic                    last_l;
    logic [2:0]              st_l;

    // {mine, ahead} of a slot as seen by that client
    function automatic logic [2:0] slot_state(slot_view_t v, tbl_stat_t st, slot_t s,
                                              logic known);
        logic   mine_l;
        wide_t  wide;
        ahead_t ah;
        mine_l = known && st.playing_valid && (st.playing_slot == s);
        wide   = {2'b00, v.rank};
        ah     = (wide > wide_t'(3)) ? 2'd3 : wide[1:0];
        if (mine_l || !known || !v.in_use || !v.waiting)
        begin
            ah = '0;
        end
        return {mine_l, ah};
    endfunction

    assign nmask        = stat.in_use & stat.subscribed;
    assign played_found = stat.playing_valid && (stat.playing_slot == found_s_reg);
    assign start_ok     = !stat.playing_valid && !stat.busy &&
                          ((view.waiting && view.rank == '0) ||
                           (!view.waiting && wait_cnt_reg == '0));
    assign cap_hit      = (cnt_reg == RES_CNT_W'(MAX_RESULTS - 1));
    assign req_ready    = (state_reg == ST_IDLE);

    always_comb
    begin
        for (int t = 0; t < CLIENT_SLOTS; t++)
        begin
            above[t] = nmask[t] && (slot_t'(t) > idx_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        req_next        = req_reg;
        found_v_next    = found_v_reg;
        found_s_next    = found_s_reg;
        free_v_next     = free_v_reg;
        free_s_next     = free_s_reg;
        head0_v_next    = head0_v_reg;
        head0_s_next    = head0_s_reg;
        head1_v_next    = head1_v_reg;
        head1_s_next    = head1_s_reg;
        wait_cnt_next   = wait_cnt_reg;
        first_kind_next = first_kind_reg;
        first_slot_next = first_slot_reg;
        has_first_next  = has_first_reg;
        do_notes_next   = do_notes_reg;
        cnt_next        = cnt_reg;
        cmd             = '0;
        emit            = 1'b0;
        res_data        = '0;
        rd_idx          = idx_reg;
        last_l          = 1'b0;
        st_l            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req_data;
                    idx_next      = '0;
                    found_v_next  = 1'b0;
                    free_v_next   = 1'b0;
                    head0_v_next  = 1'b0;
                    head1_v_next  = 1'b0;
                    wait_cnt_next = '0;
                    cnt_next      = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (view.in_use && view.conn == req_reg.conn_id && !found_v_reg)
                begin
                    found_v_next = 1'b1;
                    found_s_next = idx_reg;
                end
                if (!view.in_use && !free_v_reg)
                begin
                    free_v_next = 1'b1;
                    free_s_next = idx_reg;
                end
                if (view.in_use && view.waiting && view.rank == slot_t'(0) && !head0_v_reg)
                begin
                    head0_v_next = 1'b1;
                    head0_s_next = idx_reg;
                end
                if (view.in_use && view.waiting && view.rank == slot_t'(1) && !head1_v_reg)
                begin
                    head1_v_next = 1'b1;
                    head1_s_next = idx_reg;
                end
                if (view.in_use && view.waiting)
                begin
                    wait_cnt_next = wait_cnt_reg + cnt_t'(1);
                end
                if (idx_reg == slot_t'(CLIENT_SLOTS - 1))
                begin
                    state_next = ST_EXEC;
                end
                else
                begin
                    idx_next = idx_reg + slot_t'(1);
                end
            end

            ST_EXEC:
            begin
                rd_idx          = found_s_reg;
                has_first_next  = 1'b0;
                do_notes_next   = 1'b0;
                first_kind_next = KIND_ACCEPT;
                first_slot_next = found_s_reg;
                cmd.conn        = req_reg.conn_id;
                cmd.slot        = found_s_reg;
                unique case (req_reg.mode)
                    MODE_CONNECT:
                    begin
                        has_first_next = 1'b1;
                        if (free_v_reg)
                        begin
                            cmd.connect = 1'b1;
                            cmd.slot    = free_s_reg;
                        end
                        else
                        begin
                            first_kind_next = KIND_REFUSE;
                        end
                    end
                    MODE_DISCONNECT:
                    begin
                        if (found_v_reg)
                        begin
                            cmd.leave      = 1'b1;
                            cmd.disconnect = 1'b1;
                            do_notes_next  = 1'b1;
                            if (played_found)
                            begin
                                cmd.stop        = 1'b1;
                                has_first_next  = 1'b1;
                                first_kind_next = KIND_STOP;
                            end
                        end
                    end
                    MODE_WRITE:
                    begin
                        do_notes_next = 1'b1;
                        if (found_v_reg && !played_found)
                        begin
                            if (req_reg.cmd_byte == CH_L)
                            begin
                                cmd.leave = 1'b1;
                            end
                            else if (req_reg.cmd_byte >= CH_0 && req_reg.cmd_byte <= CH_6)
                            begin
                                cmd.set_track = 1'b1;
                                cmd.track     = track_t'(req_reg.cmd_byte - CH_0);
                                cmd.join_q    = 1'b1;
                                cmd.join_rank = wait_cnt_reg[SLOT_W-1:0];
                                if (start_ok)
                                begin
                                    cmd.start       = 1'b1;
                                    cmd.start_slot  = found_s_reg;
                                    has_first_next  = 1'b1;
                                    first_kind_next = KIND_PLAY;
                                end
                            end
                        end
                    end
                    MODE_READ:
                    begin
                        has_first_next  = 1'b1;
                        first_kind_next = KIND_REPLY;
                    end
                    MODE_SUBSCRIBE:
                    begin
                        if (found_v_reg)
                        begin
                            cmd.set_sub = 1'b1;
                            cmd.sub_val = req_reg.notify_on;
                            if (req_reg.notify_on)
                            begin
                                has_first_next  = 1'b1;
                                first_kind_next = KIND_NOTE;
                            end
                        end
                    end
                    MODE_FINISHED:
                    begin
                        cmd.clr_busy  = 1'b1;
                        cmd.stop      = 1'b1;
                        do_notes_next = 1'b1;
                        if (stat.playing_valid)
                        begin
                            cmd.leave = 1'b1;
                            cmd.slot  = stat.playing_slot;
                            if (head1_v_reg)
                            begin
                                cmd.start       = 1'b1;
                                cmd.start_slot  = head1_s_reg;
                                has_first_next  = 1'b1;
                                first_kind_next = KIND_PLAY;
                                first_slot_next = head1_s_reg;
                            end
                        end
                        else if (head0_v_reg)
                        begin
                            cmd.start       = 1'b1;
                            cmd.start_slot  = head0_s_reg;
                            has_first_next  = 1'b1;
                            first_kind_next = KIND_PLAY;
                            first_slot_next = head0_s_reg;
                        end
                    end
                    MODE_BUSY:
                    begin
                        cmd.set_busy = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                idx_next   = '0;
                state_next = ST_FIRST;
            end

            ST_FIRST:
            begin
                rd_idx = first_slot_reg;
                if (!has_first_reg)
                begin
                    if (do_notes_reg && nmask != '0)
                    begin
                        state_next = ST_NOTE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (res_free)
                begin
                    last_l               = !do_notes_reg || nmask == '0 || cap_hit;
                    st_l                 = slot_state(view, stat, first_slot_reg, found_v_reg);
                    emit                 = 1'b1;
                    res_data.kind        = first_kind_reg;
                    res_data.target_conn = req_reg.conn_id;
                    res_data.last        = last_l;
                    if (first_kind_reg == KIND_PLAY)
                    begin
                        res_data.target_conn = view.conn;
                        res_data.mine        = 1'b1;
                        res_data.track       = view.track;
                    end
                    else if (first_kind_reg == KIND_REPLY || first_kind_reg == KIND_NOTE)
                    begin
                        res_data.mine  = st_l[2];
                        res_data.ahead = st_l[1:0];
                    end
                    cnt_next   = cnt_reg + RES_CNT_W'(1);
                    state_next = last_l ? ST_IDLE : ST_NOTE;
                end
            end

            ST_NOTE:
            begin
                if (nmask[idx_reg])
                begin
                    if (res_free)
                    begin
                        last_l               = (above == '0) || cap_hit;
                        st_l                 = slot_state(view, stat, idx_reg, 1'b1);
                        emit                 = 1'b1;
                        res_data.kind        = KIND_NOTE;
                        res_data.target_conn = view.conn;
                        res_data.mine        = st_l[2];
                        res_data.ahead       = st_l[1:0];
                        res_data.last        = last_l;
                        cnt_next             = cnt_reg + RES_CNT_W'(1);
                        if (last_l || idx_reg == slot_t'(CLIENT_SLOTS - 1))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + slot_t'(1);
                        end
                    end
                end
                else if (idx_reg == slot_t'(CLIENT_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + slot_t'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            found_v_reg   <= 1'b0;
            free_v_reg    <= 1'b0;
            head0_v_reg   <= 1'b0;
            head1_v_reg   <= 1'b0;
            wait_cnt_reg  <= '0;
            has_first_reg <= 1'b0;
            do_notes_reg  <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            found_v_reg   <= found_v_next;
            free_v_reg    <= free_v_next;
            head0_v_reg   <= head0_v_next;
            head1_v_reg   <= head1_v_next;
            wait_cnt_reg  <= wait_cnt_next;
            has_first_reg <= has_first_next;
            do_notes_reg  <= do_notes_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        found_s_reg    <= found_s_next;
        free_s_reg     <= free_s_next;
        head0_s_reg    <= head0_s_next;
        head1_s_reg    <= head1_s_next;
        first_kind_reg <= first_kind_next;
        first_slot_reg <= first_slot_next;
    end

endmodule

FILE: src/fifo_client_play_queue_unit.sv
// ----------------------------------------------------------------------------
// fifo_client_play_queue_unit
// Four client slots sharing one player through a FIFO play queue.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    mode, conn_id, cmd_byte, notify_on
//   res      out  valid/ready    kind, target_conn, mine, ahead, track, last
//
// A request is taken in ST_IDLE, then come the slot scan over all
// CLIENT_SLOTS slots, the update step, the leading result and a
// notification scan over up to CLIENT_SLOTS slots.
// The slot scan and notification scan share one slot read port.
// req is not ready while a request is in hand; a stalled res holds the scan.
// The result register lets the next request in while the last result waits.
// Reset clears all queue state; handles are only read for slots in use.
// ----------------------------------------------------------------------------
module fifo_client_play_queue_unit import fcpq_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    fcpq_req_if.sink   req,
    fcpq_res_if.source res
);

    req_t       req_data;
    logic       req_ready;
    logic       emit;
    res_t       res_next;
    res_t       res_reg;
    logic       res_valid_reg, res_valid_next;
    logic       res_free;
    tbl_cmd_t   cmd;
    slot_t      rd_idx;
    slot_view_t view;
    tbl_stat_t  stat;

    assign req_data.mode      = req.mode;
    assign req_data.conn_id   = req.conn_id;
    assign req_data.cmd_byte  = req.cmd_byte;
    assign req_data.notify_on = req.notify_on;
    assign req.ready          = req_ready;

    assign res_free = !res_valid_reg || res.ready;

    fcpq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_data  (req_data),
        .req_ready (req_ready),
        .res_free  (res_free),
        .emit      (emit),
        .res_data  (res_next),
        .cmd       (cmd),
        .rd_idx    (rd_idx),
        .view      (view),
        .stat      (stat)
    );

    fcpq_slot_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .rd_idx (rd_idx),
        .view   (view),
        .stat   (stat)
    );

    always_comb
    begin
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.kind        = res_reg.kind;
    assign res.target_conn = res_reg.target_conn;
    assign res.mine        = res_reg.mine;
    assign res.ahead       = res_reg.ahead;
    assign res.track       = res_reg.track;
    assign res.last        = res_reg.last;

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the client play queue. Requests go in through
// the req channel and each one is run through a local copy of the queue
// state. The results it should cause are queued and then compared, one
// field at a time, with what appears on res. A short directed pass comes
// first, then four random passes with different sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcpq_pkg::*;

    localparam int    CLK_PERIOD     = 8;
    localparam int    RESET_CYCLES   = 8;
    localparam int    DRAIN_CYCLES   = 16;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    ERROR_PRINTS   = 100;
    localparam int    POOL_SIZE      = 6;
    localparam mode_t MODE_UNUSED    = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    fcpq_req_if req_bus ();
    fcpq_res_if res_bus ();

    fifo_client_play_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    int src_idle_pct = 0;
    int rcv_stall_pct = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    res_t  pending_results [$];
    res_t  step_results [$];
    conn_t handle_pool [POOL_SIZE];

    // shadow of the queue state
    logic   pq_used  [CLIENT_SLOTS] = '{default: 1'b0};
    conn_t  pq_conn  [CLIENT_SLOTS] = '{default: '0};
    logic   pq_sub   [CLIENT_SLOTS] = '{default: 1'b0};
    logic   pq_wait  [CLIENT_SLOTS] = '{default: 1'b0};
    slot_t  pq_rank  [CLIENT_SLOTS] = '{default: '0};
    track_t pq_track [CLIENT_SLOTS] = '{default: '0};
    logic   pq_play_v = 1'b0;
    slot_t  pq_play_s = '0;
    logic   pq_busy   = 1'b0;

    task automatic flag_error(input string msg);
        begin
            if (error_count < ERROR_PRINTS)
            begin
                $display("tb_top: error at %0t ns: %s", $time, msg);
            end
            error_count++;
        end
    endtask

    function automatic void push_result(kind_t k, conn_t c, logic m, int a, track_t t);
        res_t r;
        if (step_results.size() >= MAX_RESULTS)
        begin
            return;
        end
        r.kind        = k;
        r.target_conn = c;
        r.mine        = m;
        r.ahead       = (a > 3) ? ahead_t'(3) : ahead_t'(a);
        r.track       = t;
        r.last        = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic int head_slot();
        for (int s = 0; s < CLIENT_SLOTS; s++)
        begin
            if (pq_used[s] && pq_wait[s] && pq_rank[s] == '0)
            begin
                return s;
            end
        end
        return -1;
    endfunction

    function automatic void leave_slot(int s);
        if (!pq_wait[s])
        begin
            return;
        end
        for (int t = 0; t < CLIENT_SLOTS; t++)
        begin
            if (t != s && pq_wait[t] && pq_rank[t] > pq_rank[s])
            begin
                pq_rank[t] = pq_rank[t] - 1'b1;
            end
        end
        pq_wait[s] = 1'b0;
        pq_rank[s] = '0;
    endfunction

    function automatic logic is_playing(int s);
        return (s >= 0) && pq_play_v && (int'(pq_play_s) == s);
    endfunction

    function automatic void start_play(int s);
        pq_play_v = 1'b1;
        pq_play_s = slot_t'(s);
        push_result(KIND_PLAY, pq_conn[s], 1'b1, 0, pq_track[s]);
    endfunction

    function automatic void slot_state(int s, output logic m, output int a);
        m = is_playing(s);
        a = 0;
        if (m || s < 0)
        begin
            return;
        end
        if (!pq_used[s] || !pq_wait[s])
        begin
            return;
        end
        for (int t = 0; t < CLIENT_SLOTS; t++)
        begin
            if (pq_used[t] && pq_wait[t] && pq_rank[t] < pq_rank[s])
            begin
                a++;
            end
        end
    endfunction

    function automatic void notify_slot(int s);
        logic m;
        int   a;
        if (s < 0)
        begin
            return;
        end
        if (!pq_used[s] || !pq_sub[s])
        begin
            return;
        end
        slot_state(s, m, a);
        push_result(KIND_NOTE, pq_conn[s], m, a, '0);
    endfunction

    function automatic void notify_subscribers();
        for (int s = 0; s < CLIENT_SLOTS; s++)
        begin
            notify_slot(s);
        end
    endfunction

    // works out the results of one accepted request and updates the shadow
    function automatic void predict_queue_results(req_t r);
        int   s;
        int   t;
        int   n;
        logic m;
        int   a;
        step_results.delete();
        s = -1;
        for (int i = 0; i < CLIENT_SLOTS; i++)
        begin
            if (s < 0 && pq_used[i] && pq_conn[i] == r.conn_id)
            begin
                s = i;
            end
        end
        case (r.mode)
            MODE_CONNECT:
            begin
                t = -1;
                for (int i = 0; i < CLIENT_SLOTS; i++)
                begin
                    if (t < 0 && !pq_used[i])
                    begin
                        t = i;
                    end
                end
                if (t < 0)
                begin
                    push_result(KIND_REFUSE, r.conn_id, 1'b0, 0, '0);
                end
                else
                begin
                    pq_used[t]  = 1'b1;
                    pq_conn[t]  = r.conn_id;
                    pq_sub[t]   = 1'b0;
                    pq_wait[t]  = 1'b0;
                    pq_rank[t]  = '0;
                    pq_track[t] = '0;
                    push_result(KIND_ACCEPT, r.conn_id, 1'b0, 0, '0);
                end
            end
            MODE_DISCONNECT:
            begin
                if (s >= 0)
                begin
                    leave_slot(s);
                    if (is_playing(s))
                    begin
                        pq_play_v = 1'b0;
                        pq_play_s = '0;
                        push_result(KIND_STOP, r.conn_id, 1'b0, 0, '0);
                    end
                    pq_used[s] = 1'b0;
                    pq_sub[s]  = 1'b0;
                    notify_subscribers();
                end
            end
            MODE_WRITE:
            begin
                if (r.cmd_byte == CH_L)
                begin
                    if (s >= 0 && !is_playing(s))
                    begin
                        leave_slot(s);
                    end
                end
                else if (r.cmd_byte >= CH_0 && r.cmd_byte <= CH_6)
                begin
                    if (s >= 0 && !is_playing(s))
                    begin
                        pq_track[s] = track_t'(r.cmd_byte - CH_0);
                        if (!pq_wait[s])
                        begin
                            n = 0;
                            for (int i = 0; i < CLIENT_SLOTS; i++)
                            begin
                                if (pq_used[i] && pq_wait[i])
                                begin
                                    n++;
                                end
                            end
                            pq_wait[s] = 1'b1;
                            pq_rank[s] = slot_t'(n);
                        end
                        if (!pq_play_v && !pq_busy && head_slot() == s)
                        begin
                            start_play(s);
                        end
                    end
                end
                notify_subscribers();
            end
            MODE_READ:
            begin
                slot_state(s, m, a);
                push_result(KIND_REPLY, r.conn_id, m, a, '0);
            end
            MODE_SUBSCRIBE:
            begin
                if (s >= 0)
                begin
                    pq_sub[s] = r.notify_on;
                    notify_slot(s);
                end
            end
            MODE_FINISHED:
            begin
                pq_busy = 1'b0;
                if (pq_play_v)
                begin
                    t = int'(pq_play_s);
                    if (pq_used[t])
                    begin
                        leave_slot(t);
                    end
                end
                pq_play_v = 1'b0;
                pq_play_s = '0;
                t = head_slot();
                if (t >= 0)
                begin
                    start_play(t);
                end
                notify_subscribers();
            end
            MODE_BUSY:
            begin
                pq_busy = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (step_results.size() > 0)
        begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
        foreach (step_results[i])
        begin
            pending_results.push_back(step_results[i]);
        end
    endfunction

    // one request: optional gap, then hold valid until taken
    task automatic send_request(input mode_t m, input conn_t c, input logic [7:0] b,
                                input logic on);
        req_t r;
        begin
            r.mode      = m;
            r.conn_id   = c;
            r.cmd_byte  = b;
            r.notify_on = on;
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct)
            begin
                req_bus.valid <= 1'b0;
                @(negedge clk);
            end
            req_bus.valid     <= 1'b1;
            req_bus.mode      <= r.mode;
            req_bus.conn_id   <= r.conn_id;
            req_bus.cmd_byte  <= r.cmd_byte;
            req_bus.notify_on <= r.notify_on;
            @(posedge clk);
            while (req_bus.ready !== 1'b1)
            begin
                @(posedge clk);
            end
            predict_queue_results(r);
        end
    endtask

    task automatic drain();
        begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic run_random(input int n_items);
        req_t r;
        int   done;
        int   pick;
        begin
            done = 0;
            handle_pool[4] = conn_t'($urandom);
            handle_pool[5] = conn_t'($urandom);
            while (done < n_items)
            begin
                r.notify_on = 1'($urandom_range(1));
                r.cmd_byte  = 8'($urandom);
                if ($urandom_range(99) < 88)
                begin
                    r.conn_id = handle_pool[$urandom_range(POOL_SIZE - 1)];
                end
                else
                begin
                    r.conn_id = conn_t'($urandom);
                end
                pick = $urandom_range(99);
                if (pick < 12)
                    r.mode = MODE_CONNECT;
                else if (pick < 20)
                    r.mode = MODE_DISCONNECT;
                else if (pick < 58)
                    r.mode = MODE_WRITE;
                else if (pick < 66)
                    r.mode = MODE_READ;
                else if (pick < 76)
                    r.mode = MODE_SUBSCRIBE;
                else if (pick < 90)
                    r.mode = MODE_FINISHED;
                else if (pick < 96)
                    r.mode = MODE_BUSY;
                else
                    r.mode = MODE_UNUSED;
                if (r.mode == MODE_WRITE)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        r.cmd_byte = CH_0 + 8'($urandom_range(6));
                    else if (pick < 85)
                        r.cmd_byte = CH_L;
                end
                send_request(r.mode, r.conn_id, r.cmd_byte, r.notify_on);
                if (r.mode != MODE_UNUSED)
                begin
                    done++;
                end
            end
        end
    endtask

    task automatic test_directed();
        conn_t h0;
        conn_t h1;
        conn_t h2;
        conn_t hx;
        begin
            h0 = 16'h0000;
            h1 = 16'hFFFF;
            h2 = 16'h5A3C;
            hx = 16'hC3A5;
            src_idle_pct  = 0;
            rcv_stall_pct = 0;
            send_request(MODE_CONNECT, h0, 8'h00, 1'b0);
            send_request(MODE_CONNECT, h1, 8'hFF, 1'b1);
            send_request(MODE_CONNECT, h2, 8'h00, 1'b0);
            send_request(MODE_CONNECT, h2, 8'h00, 1'b0);    // duplicate handle
            send_request(MODE_CONNECT, hx, 8'h00, 1'b0);    // all slots taken
            send_request(MODE_SUBSCRIBE, h0, 8'h00, 1'b1);
            send_request(MODE_SUBSCRIBE, h1, 8'h00, 1'b1);
            send_request(MODE_WRITE, h0, CH_0, 1'b0);       // idle player, starts
            send_request(MODE_WRITE, h1, CH_6, 1'b0);
            send_request(MODE_WRITE, h2, CH_0 + 8'd3, 1'b0);
            send_request(MODE_WRITE, h1, CH_0 + 8'd5, 1'b0); // new track while waiting
            send_request(MODE_WRITE, h0, CH_0 + 8'd4, 1'b0); // played slot, ignored
            send_request(MODE_WRITE, h0, CH_L, 1'b0);        // played slot stays
            send_request(MODE_WRITE, h2, CH_L, 1'b0);
            send_request(MODE_WRITE, h1, CH_6 + 8'd1, 1'b0); // other byte
            send_request(MODE_WRITE, hx, CH_0 + 8'd2, 1'b0); // unknown handle
            send_request(MODE_READ, h0, 8'h00, 1'b0);
            send_request(MODE_READ, h1, 8'h00, 1'b0);
            send_request(MODE_READ, hx, 8'h00, 1'b0);
            send_request(MODE_BUSY, h0, 8'h00, 1'b0);
            send_request(MODE_FINISHED, h0, 8'h00, 1'b0);
            send_request(MODE_DISCONNECT, h1, 8'h00, 1'b0);  // stop request
            send_request(MODE_WRITE, h2, CH_0 + 8'd1, 1'b0);
            send_request(MODE_FINISHED, h0, 8'h00, 1'b0);
            send_request(MODE_FINISHED, h0, 8'h00, 1'b0);    // nothing playing
            send_request(MODE_UNUSED, h0, 8'h00, 1'b1);
            send_request(MODE_SUBSCRIBE, h0, 8'h00, 1'b0);
            send_request(MODE_DISCONNECT, hx, 8'h00, 1'b0);
            drain();
        end
    endtask

    task automatic test_random_flow();
        begin
            src_idle_pct  = 0;
            rcv_stall_pct = 0;
            run_random(100);
            drain();
        end
    endtask

    task automatic test_sender_idle();
        begin
            src_idle_pct  = 63;
            rcv_stall_pct = 0;
            run_random(100);
            drain();
        end
    endtask

    task automatic test_receiver_stall();
        begin
            src_idle_pct  = 0;
            rcv_stall_pct = 63;
            run_random(100);
            drain();
        end
    endtask

    task automatic test_both_idle();
        begin
            src_idle_pct  = 18;
            rcv_stall_pct = 18;
            run_random(100);
            drain();
        end
    endtask

    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t exp;
        if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            got.kind        = res_bus.kind;
            got.target_conn = res_bus.target_conn;
            got.mine        = res_bus.mine;
            got.ahead       = res_bus.ahead;
            got.track       = res_bus.track;
            got.last        = res_bus.last;
            if (pending_results.size() == 0)
            begin
                flag_error($sformatf("unexpected result kind=%0d conn=%h",
                                     got.kind, got.target_conn));
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.kind !== exp.kind || got.target_conn !== exp.target_conn ||
                    got.mine !== exp.mine || got.ahead !== exp.ahead ||
                    got.track !== exp.track || got.last !== exp.last)
                begin
                    flag_error($sformatf(
                        "got k=%0d c=%h m=%b a=%0d t=%0d l=%b, exp k=%0d c=%h m=%b a=%0d t=%0d l=%b",
                        got.kind, got.target_conn, got.mine, got.ahead, got.track, got.last,
                        exp.kind, exp.target_conn, exp.mine, exp.ahead, exp.track, exp.last));
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.mode      = MODE_CONNECT;
        req_bus.conn_id   = '0;
        req_bus.cmd_byte  = '0;
        req_bus.notify_on = 1'b0;
        handle_pool[0] = 16'h0000;
        handle_pool[1] = 16'hFFFF;
        handle_pool[2] = conn_t'($urandom);
        handle_pool[3] = conn_t'($urandom);
        handle_pool[4] = conn_t'($urandom);
        handle_pool[5] = conn_t'($urandom);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_flow();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        if (pending_results.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (error_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
